@@ rtl/core/bmpc_pkg.sv @@
package bmpc_pkg;

   // header layout
   localparam int unsigned HEADER_BYTES = 54;
   localparam int unsigned HDR_IDX_W = 6;

   localparam logic [HDR_IDX_W-1:0] OFS_WIDTH_LO  = HDR_IDX_W'(18);
   localparam logic [HDR_IDX_W-1:0] OFS_WIDTH_HI  = HDR_IDX_W'(19);
   localparam logic [HDR_IDX_W-1:0] OFS_HEIGHT_LO = HDR_IDX_W'(22);
   localparam logic [HDR_IDX_W-1:0] OFS_HEIGHT_HI = HDR_IDX_W'(23);
   localparam logic [HDR_IDX_W-1:0] OFS_BPP       = HDR_IDX_W'(28);
   localparam logic [HDR_IDX_W-1:0] OFS_SIZE_B0   = HDR_IDX_W'(8'h22);
   localparam logic [HDR_IDX_W-1:0] OFS_SIZE_B1   = HDR_IDX_W'(8'h23);
   localparam logic [HDR_IDX_W-1:0] OFS_SIZE_B2   = HDR_IDX_W'(8'h24);
   localparam logic [HDR_IDX_W-1:0] OFS_SIZE_B3   = HDR_IDX_W'(8'h25);
   localparam logic [HDR_IDX_W-1:0] HDR_LAST      = HDR_IDX_W'(HEADER_BYTES - 1);

   localparam logic [7:0] BPP_24 = 8'd24;

   // result kinds
   localparam logic [1:0] KIND_WINDOW = 2'd0;
   localparam logic [1:0] KIND_PIXEL  = 2'd1;
   localparam logic [1:0] KIND_END    = 2'd2;

   // register map
   localparam logic REG_PANEL_WIDTH  = 1'b0;
   localparam logic REG_PANEL_HEIGHT = 1'b1;
   localparam logic [9:0] PANEL_WIDTH_RST  = 10'd320;
   localparam logic [9:0] PANEL_HEIGHT_RST = 10'd240;

   // result queue
   localparam int unsigned RQ_DEPTH = 4;
   localparam int unsigned RQ_PTR_W = 2;
   localparam int unsigned RQ_CNT_W = 3;

   typedef struct packed {
      logic [1:0]  kind;
      logic [9:0]  y_start;
      logic [9:0]  x_end;
      logic [9:0]  y_end;
      logic [15:0] pixel;
      logic        last;
   } result_type;

endpackage

@@ rtl/core/bmp24_stream_to_rgb565.sv @@
// a result reaches the rsp_ side from the registered result queue, behind any results already queued
// one byte per cycle while req_stall is low; a byte that causes two results (window plus end, or pixel
//    plus end) writes both at once into a four-entry result queue
// req_stall rises only when the queue has fewer than two free entries
// reset (synchronous, active high): parser idle until a byte with file_start, queue empty,
//    panel_width 320, panel_height 240
module bmp24_stream_to_rgb565 (
   input  logic        clock,
   input  logic        reset,
   // byte stream in
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_file_start,
   // result stream out
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [9:0]  rsp_x_start,
   output logic [9:0]  rsp_y_start,
   output logic [9:0]  rsp_x_end,
   output logic [9:0]  rsp_y_end,
   output logic [15:0] rsp_pixel_rgb565,
   output logic        rsp_last,
   // configuration port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import bmpc_pkg::*;

   // ---------------------------------------------------------------
   // configuration registers
   // ---------------------------------------------------------------
   logic [9:0] panel_width_ff;
   logic [9:0] panel_height_ff;
   logic       csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         panel_width_ff  <= PANEL_WIDTH_RST;
         panel_height_ff <= PANEL_HEIGHT_RST;
      end else if (csr_write) begin
         // word aligned decode, bit 2 picks the register
         if (csr_paddr[2] == REG_PANEL_WIDTH) begin
            panel_width_ff <= csr_pwdata[9:0];
         end else begin
            panel_height_ff <= csr_pwdata[9:0];
         end
      end
   end

   always_comb begin
      if (csr_paddr[2] == REG_PANEL_HEIGHT) begin
         csr_prdata = {22'd0, panel_height_ff};
      end else begin
         csr_prdata = {22'd0, panel_width_ff};
      end
   end

   // ---------------------------------------------------------------
   // parser state
   // ---------------------------------------------------------------
   logic [HDR_IDX_W-1:0] hdr_idx_ff,   hdr_idx_in,   hdr_idx_cur;
   logic [31:0]          remain_ff,    remain_in,    remain_cur;
   logic [15:0]          width_ff,     width_in,     width_cur;
   logic [15:0]          height_ff,    height_in,    height_cur;
   logic [7:0]           bpp_ff,       bpp_in,       bpp_cur;
   logic [1:0]           row_pad_ff,   row_pad_in,   row_pad_cur;
   logic [1:0]           pad_skip_ff,  pad_skip_in,  pad_skip_cur;
   logic [15:0]          pix_cnt_ff,   pix_cnt_in,   pix_cnt_cur;
   logic [1:0]           byte_sel_ff,  byte_sel_in,  byte_sel_cur;
   logic [7:0]           blue_ff,      blue_in,      blue_cur;
   logic [7:0]           green_ff,     green_in,     green_cur;
   logic                 error_ff,     error_in,     error_cur;
   logic                 done_ff,      done_in,      done_cur;

   logic       req_accept;
   logic [1:0] res_count;     // results caused by this byte, 0 to 2
   result_type res0;
   result_type res1;
   logic [31:0] remain_dec;
   logic [15:0] pix_cnt_inc;
   logic [1:0]  pad_skip_dec;
   logic        bad_image;

   assign req_accept = req_valid && !req_stall;

   // file_start restarts everything and the same byte is header byte zero
   always_comb begin
      if (req_file_start) begin
         hdr_idx_cur  = '0;
         remain_cur   = '0;
         width_cur    = '0;
         height_cur   = '0;
         bpp_cur      = '0;
         row_pad_cur  = '0;
         pad_skip_cur = '0;
         pix_cnt_cur  = '0;
         byte_sel_cur = '0;
         blue_cur     = '0;
         green_cur    = '0;
         error_cur    = 1'b0;
         done_cur     = 1'b0;
      end else begin
         hdr_idx_cur  = hdr_idx_ff;
         remain_cur   = remain_ff;
         width_cur    = width_ff;
         height_cur   = height_ff;
         bpp_cur      = bpp_ff;
         row_pad_cur  = row_pad_ff;
         pad_skip_cur = pad_skip_ff;
         pix_cnt_cur  = pix_cnt_ff;
         byte_sel_cur = byte_sel_ff;
         blue_cur     = blue_ff;
         green_cur    = green_ff;
         error_cur    = error_ff;
         done_cur     = done_ff;
      end
   end

   always_comb begin
      hdr_idx_in  = hdr_idx_cur;
      remain_in   = remain_cur;
      width_in    = width_cur;
      height_in   = height_cur;
      bpp_in      = bpp_cur;
      row_pad_in  = row_pad_cur;
      pad_skip_in = pad_skip_cur;
      pix_cnt_in  = pix_cnt_cur;
      byte_sel_in = byte_sel_cur;
      blue_in     = blue_cur;
      green_in    = green_cur;
      error_in    = error_cur;
      done_in     = done_cur;
      res_count   = 2'd0;
      res0        = '0;
      res1        = '0;

      remain_dec   = (remain_cur != 32'd0) ? remain_cur - 32'd1 : 32'd0;
      pix_cnt_inc  = pix_cnt_cur + 16'd1;
      pad_skip_dec = pad_skip_cur - 2'd1;
      bad_image    = 1'b0;

      if (!(done_cur || error_cur)) begin
         if (hdr_idx_cur < HDR_IDX_W'(HEADER_BYTES)) begin
            // header: capture the little-endian fields
            case (hdr_idx_cur)
               OFS_WIDTH_LO:  width_in  = {width_cur[15:8], req_data_byte};
               OFS_WIDTH_HI:  width_in  = {req_data_byte, width_cur[7:0]};
               OFS_HEIGHT_LO: height_in = {height_cur[15:8], req_data_byte};
               OFS_HEIGHT_HI: height_in = {req_data_byte, height_cur[7:0]};
               OFS_BPP:       bpp_in    = req_data_byte;
               OFS_SIZE_B0:   remain_in = {remain_cur[31:8], req_data_byte};
               OFS_SIZE_B1:   remain_in = {remain_cur[31:16], req_data_byte, remain_cur[7:0]};
               OFS_SIZE_B2:   remain_in = {remain_cur[31:24], req_data_byte, remain_cur[15:0]};
               OFS_SIZE_B3:   remain_in = {req_data_byte, remain_cur[23:0]};
               default: ;
            endcase
            hdr_idx_in = hdr_idx_cur + HDR_IDX_W'(1);

            if (hdr_idx_cur == HDR_LAST) begin
               bad_image = (bpp_in != BPP_24) ||
                           (width_in > {6'd0, panel_width_ff}) ||
                           (height_in > {6'd0, panel_height_ff}) ||
                           (width_in == 16'd0) || (height_in == 16'd0);
               if (bad_image) begin
                  error_in = 1'b1;
               end else begin
                  row_pad_in   = width_in[1:0];
                  pix_cnt_in   = '0;
                  byte_sel_in  = '0;
                  pad_skip_in  = '0;
                  res0.kind    = KIND_WINDOW;
                  res0.y_start = panel_height_ff - height_in[9:0];
                  res0.x_end   = width_in[9:0] - 10'd1;
                  res0.y_end   = panel_height_ff - 10'd1;
                  res_count    = 2'd1;
                  // no room for even one pixel: end right behind the window
                  if (remain_in < 32'd3) begin
                     res1.kind = KIND_END;
                     res1.last = 1'b1;
                     done_in   = 1'b1;
                     res_count = 2'd2;
                  end else begin
                     res0.last = 1'b1;
                  end
               end
            end
         end else begin
            // pixel data: every byte counts down, padding included
            remain_in = remain_dec;
            if (pad_skip_cur != 2'd0) begin
               pad_skip_in = pad_skip_dec;
               if (pad_skip_dec == 2'd0 && remain_dec < 32'd3) begin
                  res0.kind = KIND_END;
                  res0.last = 1'b1;
                  done_in   = 1'b1;
                  res_count = 2'd1;
               end
            end else begin
               case (byte_sel_cur)
                  2'd0: begin
                     blue_in     = req_data_byte;
                     byte_sel_in = 2'd1;
                  end
                  2'd1: begin
                     green_in    = req_data_byte;
                     byte_sel_in = 2'd2;
                  end
                  default: begin
                     byte_sel_in = 2'd0;
                     res0.kind   = KIND_PIXEL;
                     res0.pixel  = {req_data_byte[7:3], green_cur[7:2], blue_cur[7:3]};
                     res_count   = 2'd1;
                     pix_cnt_in  = pix_cnt_inc;
                     if (pix_cnt_inc == width_cur) begin
                        pix_cnt_in  = '0;
                        pad_skip_in = row_pad_cur;
                     end
                     if (remain_dec < 32'd3) begin
                        res1.kind = KIND_END;
                        res1.last = 1'b1;
                        done_in   = 1'b1;
                        res_count = 2'd2;
                     end else begin
                        res0.last = 1'b1;
                     end
                  end
               endcase
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_idx_ff  <= '0;
         remain_ff   <= '0;
         width_ff    <= '0;
         height_ff   <= '0;
         bpp_ff      <= '0;
         row_pad_ff  <= '0;
         pad_skip_ff <= '0;
         pix_cnt_ff  <= '0;
         byte_sel_ff <= '0;
         blue_ff     <= '0;
         green_ff    <= '0;
         error_ff    <= 1'b0;
         done_ff     <= 1'b1;
      end else if (req_accept) begin
         hdr_idx_ff  <= hdr_idx_in;
         remain_ff   <= remain_in;
         width_ff    <= width_in;
         height_ff   <= height_in;
         bpp_ff      <= bpp_in;
         row_pad_ff  <= row_pad_in;
         pad_skip_ff <= pad_skip_in;
         pix_cnt_ff  <= pix_cnt_in;
         byte_sel_ff <= byte_sel_in;
         blue_ff     <= blue_in;
         green_ff    <= green_in;
         error_ff    <= error_in;
         done_ff     <= done_in;
      end
   end

   // ---------------------------------------------------------------
   // result queue, up to two writes and one read per cycle
   // ---------------------------------------------------------------
   result_type           rq_ff [RQ_DEPTH];
   logic [RQ_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [RQ_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [RQ_CNT_W-1:0]  count_ff,  count_in;
   logic [1:0]           push_count;
   logic                 rsp_pop;
   logic [RQ_PTR_W-1:0]  wr_ptr_next1;
   result_type           head;

   assign push_count   = req_accept ? res_count : 2'd0;
   assign rsp_pop      = rsp_valid && !rsp_stall;
   assign wr_ptr_next1 = wr_ptr_ff + RQ_PTR_W'(1);
   assign wr_ptr_in    = wr_ptr_ff + RQ_PTR_W'(push_count);
   assign rd_ptr_in    = rd_ptr_ff + RQ_PTR_W'(rsp_pop);
   assign count_in     = count_ff + RQ_CNT_W'(push_count) - RQ_CNT_W'(rsp_pop);

   // room for the worst case of two results per byte
   assign req_stall = count_ff > RQ_CNT_W'(RQ_DEPTH - 2);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         rq_ff[wr_ptr_ff] <= res0;
      end
      if (push_count == 2'd2) begin
         rq_ff[wr_ptr_next1] <= res1;
      end
   end

   assign head = rq_ff[rd_ptr_ff];

   assign rsp_valid        = count_ff != '0;
   assign rsp_kind         = head.kind;
   assign rsp_x_start      = 10'd0;
   assign rsp_y_start      = head.y_start;
   assign rsp_x_end        = head.x_end;
   assign rsp_y_end        = head.y_end;
   assign rsp_pixel_rgb565 = head.pixel;
   assign rsp_last         = head.last;

endmodule
